FILE: rtl/fstm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fstm_pkg
// shared types, constants and helpers of the flat span texture mapper
// ---------------------------------------------------------------------------
package fstm_pkg;

    localparam int LANES    = 8;
    localparam int LANE_W   = 3;
    localparam int LEN_W    = 11;
    localparam int COORD_W  = 10;
    localparam int SCREEN_W = 11;
    localparam int POS_W    = 32;
    localparam int TEX_AW   = 12;
    localparam int SHADE_AW = 8;
    localparam int PIX_W    = 8;
    localparam int CNT_W    = 4;
    localparam int CFG_IW   = 2;

    typedef enum logic [1:0] {
        OP_LOAD_TEXEL = 2'd0,
        OP_LOAD_SHADE = 2'd1,
        OP_DRAW       = 2'd2,
        OP_UNUSED     = 2'd3
    } op_t;

    typedef enum logic [CFG_IW-1:0] {
        CFG_WINDOW_LEFT = 2'd0,
        CFG_WINDOW_TOP  = 2'd1,
        CFG_BYPASS      = 2'd2,
        CFG_NONE        = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic              accept;
        logic              issue;
        logic [LANE_W-1:0] lane;
        logic              group_end;
        logic              span_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic             draw_ok;
        logic [LEN_W-1:0] span_len;
    } dp_status_t;

    // u integer.fraction bits to the top half, v to the bottom half, 6.10 each
    function automatic logic [POS_W-1:0] pack_pair(input logic [31:0] u,
                                                    input logic [31:0] v);
        return {u[21:6], v[21:6]};
    endfunction

    // texel address v*64+u from the packed position
    function automatic logic [TEX_AW-1:0] texel_spot(input logic [POS_W-1:0] pos);
        return {pos[15:10], pos[31:26]};
    endfunction

endpackage

FILE: rtl/fstm_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fstm_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module fstm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/fstm_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fstm_ctrl
// sequencer: accepts items, walks the pixels of a span, drains the pipeline
// ---------------------------------------------------------------------------
module fstm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  fstm_pkg::dp_status_t   status,
    output fstm_pkg::ctrl_cmd_t    cmd
);

    import fstm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    localparam logic [1:0] DRAIN_CYCLES = 2'd3;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] done_reg, done_next;
    logic [1:0]       drain_reg, drain_next;
    logic             accept;
    logic             final_pixel;

    assign busy        = (state_reg != ST_IDLE);
    assign accept      = start && !busy;
    assign final_pixel = (done_reg == len_reg - LEN_W'(1));

    always_comb
    begin
        cmd.accept    = accept;
        cmd.issue     = (state_reg == ST_RUN);
        cmd.lane      = done_reg[LANE_W-1:0];
        cmd.span_last = final_pixel;
        cmd.group_end = final_pixel || (done_reg[LANE_W-1:0] == LANE_W'(LANES - 1));
    end

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        done_next  = done_reg;
        drain_next = drain_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.draw_ok)
                begin
                    state_next = ST_RUN;
                    len_next   = status.span_len;
                    done_next  = '0;
                end
            end
            ST_RUN:
            begin
                done_next = done_reg + LEN_W'(1);
                if (final_pixel)
                begin
                    state_next = ST_DRAIN;
                    drain_next = DRAIN_CYCLES;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg - 2'd1;
                if (drain_reg == 2'd1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            done_reg  <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            done_reg  <= done_next;
            drain_reg <= drain_next;
        end
    end

    a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> done_reg < len_reg)
        else $error("pixel counter past span length");

    a_last_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue && cmd.span_last |=> state_reg == ST_DRAIN)
        else $error("final pixel not followed by drain");

    a_draw_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && status.draw_ok |-> status.span_len != '0)
        else $error("draw accepted with empty span");

endmodule

FILE: rtl/fstm_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fstm_datapath
// texel and shade stores, position stepping, group assembly, config registers
// ---------------------------------------------------------------------------
module fstm_datapath #(
    parameter int MAX_SPAN    = 512,
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fstm_pkg::ctrl_cmd_t           cmd,
    output fstm_pkg::dp_status_t          status,
    input  logic [1:0]                    operation,
    input  logic [11:0]                   table_index,
    input  logic [7:0]                    table_value,
    input  logic [9:0]                    start_column,
    input  logic [9:0]                    end_column,
    input  logic [9:0]                    span_row,
    input  logic signed [31:0]            u_start,
    input  logic signed [31:0]            v_start,
    input  logic signed [31:0]            u_step,
    input  logic signed [31:0]            v_step,
    input  logic                          cfg_valid,
    input  logic [fstm_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [9:0]                    cfg_data,
    output logic                          strobe,
    output logic [10:0]                   group_column,
    output logic [10:0]                   group_row,
    output logic [63:0]                   pixel_group,
    output logic [3:0]                    pixel_count,
    output logic                          last_group,
    output logic                          span_cut
);

    import fstm_pkg::*;

    localparam logic [LEN_W-1:0] MAX_COLS_L = LEN_W'(MAX_COLUMNS);
    localparam logic [LEN_W-1:0] MAX_SPAN_L = LEN_W'(MAX_SPAN);

    op_t                 op;
    logic [LEN_W-1:0]    x1_ext, x2_raw, x2_clamp, raw_len;
    logic                cut_now;

    logic [COORD_W-1:0]  window_left_reg, window_top_reg;
    logic                bypass_reg;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    step_reg;
    logic [SCREEN_W-1:0] grp_col_reg, grp_col_next;
    logic [SCREEN_W-1:0] row_reg;
    logic                cut_reg;

    logic                tex_we, shade_we;
    logic [PIX_W-1:0]    tex_rdata, shade_rdata;

    logic                valid_s1_reg, valid_s2_reg;
    logic [LANE_W-1:0]   lane_s1_reg, lane_s2_reg;
    logic                gend_s1_reg, gend_s2_reg;
    logic                last_s1_reg, last_s2_reg;
    logic [PIX_W-1:0]    texel_s2_reg;

    logic [PIX_W-1:0]    pixel;
    logic [63:0]         acc_reg, acc_next, acc_base;

    logic                strobe_reg;
    logic [SCREEN_W-1:0] out_col_reg;
    logic [63:0]         out_group_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic                out_last_reg;

    assign op = op_t'(operation);

    // span length and checks
    always_comb
    begin
        x1_ext   = LEN_W'(start_column);
        x2_raw   = LEN_W'(end_column);
        x2_clamp = (x2_raw >= MAX_COLS_L) ? (MAX_COLS_L - LEN_W'(1)) : x2_raw;
        raw_len  = x2_clamp - x1_ext + LEN_W'(1);
        cut_now  = (raw_len > MAX_SPAN_L);
        status.draw_ok  = (op == OP_DRAW) && (x1_ext < MAX_COLS_L) && (x2_clamp >= x1_ext);
        status.span_len = cut_now ? MAX_SPAN_L : raw_len;
    end

    // table loads
    assign tex_we   = cmd.accept && (op == OP_LOAD_TEXEL);
    assign shade_we = cmd.accept && (op == OP_LOAD_SHADE) && (table_index[11:8] == 4'd0);

    fstm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (1 << TEX_AW)
    ) u_texture_ram (
        .clk     (clk),
        .wr_en   (tex_we),
        .wr_addr (table_index),
        .wr_data (table_value),
        .rd_addr (texel_spot(pos_reg)),
        .rd_data (tex_rdata)
    );

    fstm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (1 << SHADE_AW)
    ) u_shade_ram (
        .clk     (clk),
        .wr_en   (shade_we),
        .wr_addr (table_index[SHADE_AW-1:0]),
        .wr_data (table_value),
        .rd_addr (tex_rdata),
        .rd_data (shade_rdata)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_left_reg <= '0;
            window_top_reg  <= '0;
            bypass_reg      <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_WINDOW_LEFT: window_left_reg <= cfg_data;
                CFG_WINDOW_TOP:  window_top_reg  <= cfg_data;
                CFG_BYPASS:      bypass_reg      <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // span setup and position walk
    always_comb
    begin
        pos_next     = pos_reg;
        grp_col_next = grp_col_reg;
        if (cmd.accept)
        begin
            pos_next     = pack_pair(u_start, v_start);
            grp_col_next = SCREEN_W'(window_left_reg) + SCREEN_W'(start_column);
        end
        else
        begin
            if (cmd.issue)
            begin
                pos_next = pos_reg + step_reg;
            end
            if (valid_s2_reg && gend_s2_reg)
            begin
                grp_col_next = grp_col_reg + SCREEN_W'(LANES);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        grp_col_reg <= grp_col_next;
        if (cmd.accept)
        begin
            step_reg <= pack_pair(u_step, v_step);
            row_reg  <= SCREEN_W'(window_top_reg) + SCREEN_W'(span_row);
            cut_reg  <= cut_now;
        end
    end

    // read pipeline tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
            valid_s2_reg <= 1'b0;
        end
        else
        begin
            valid_s1_reg <= cmd.issue;
            valid_s2_reg <= valid_s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_s1_reg  <= cmd.lane;
        gend_s1_reg  <= cmd.group_end;
        last_s1_reg  <= cmd.span_last;
        lane_s2_reg  <= lane_s1_reg;
        gend_s2_reg  <= gend_s1_reg;
        last_s2_reg  <= last_s1_reg;
        texel_s2_reg <= tex_rdata;
    end

    // group assembly
    always_comb
    begin
        pixel    = bypass_reg ? texel_s2_reg : shade_rdata;
        acc_base = (lane_s2_reg == '0) ? 64'd0 : acc_reg;
        acc_next = acc_base;
        acc_next[lane_s2_reg*PIX_W +: PIX_W] = pixel;
    end

    always_ff @(posedge clk)
    begin
        if (valid_s2_reg)
        begin
            acc_reg <= acc_next;
        end
        if (valid_s2_reg && gend_s2_reg)
        begin
            out_col_reg   <= grp_col_reg;
            out_group_reg <= acc_next;
            out_count_reg <= CNT_W'(lane_s2_reg) + CNT_W'(1);
            out_last_reg  <= last_s2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= valid_s2_reg && gend_s2_reg;
        end
    end

    assign strobe       = strobe_reg;
    assign group_column = out_col_reg;
    assign group_row    = row_reg;
    assign pixel_group  = out_group_reg;
    assign pixel_count  = out_count_reg;
    assign last_group   = out_last_reg;
    assign span_cut     = cut_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> (out_count_reg != '0) && (out_count_reg <= CNT_W'(LANES)))
        else $error("group beat with bad pixel count");

    a_group_beat: assert property (@(posedge clk) disable iff (!rst_n)
        valid_s2_reg && gend_s2_reg |=> strobe_reg)
        else $error("group end without result beat");

endmodule

FILE: rtl/flat_span_texture_mapper.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flat_span_texture_mapper
// affine span texture mapper over a 64x64 byte texture with shade lookup
// ---------------------------------------------------------------------------
// loads leave busy low, so the next item is taken at once
// a draw of N pixels walks one pixel per cycle through the texel and shade
// read ports, and busy stays high until the pipeline has drained
// each group of up to 8 pixels leaves from the output register once filled
// reset clears control state and config registers; both stores hold
// unknown data until loaded, no clearing pass
module flat_span_texture_mapper #(
    parameter int MAX_SPAN    = 512,
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  operation,
    input  logic [11:0]                 table_index,
    input  logic [7:0]                  table_value,
    input  logic [9:0]                  start_column,
    input  logic [9:0]                  end_column,
    input  logic [9:0]                  span_row,
    input  logic signed [31:0]          u_start,
    input  logic signed [31:0]          v_start,
    input  logic signed [31:0]          u_step,
    input  logic signed [31:0]          v_step,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fstm_pkg::CFG_IW-1:0] cfg_index,
    input  logic [9:0]                  cfg_data,
    output logic                        strobe,
    output logic [10:0]                 group_column,
    output logic [10:0]                 group_row,
    output logic [63:0]                 pixel_group,
    output logic [3:0]                  pixel_count,
    output logic                        last_group,
    output logic                        span_cut
);

    import fstm_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    fstm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    fstm_datapath #(
        .MAX_SPAN    (MAX_SPAN),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operation    (operation),
        .table_index  (table_index),
        .table_value  (table_value),
        .start_column (start_column),
        .end_column   (end_column),
        .span_row     (span_row),
        .u_start      (u_start),
        .v_start      (v_start),
        .u_step       (u_step),
        .v_step       (v_step),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .strobe       (strobe),
        .group_column (group_column),
        .group_row    (group_row),
        .pixel_group  (pixel_group),
        .pixel_count  (pixel_count),
        .last_group   (last_group),
        .span_cut     (span_cut)
    );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the flat span texture mapper
// ---------------------------------------------------------------------------
// Fills texel row 0 and the low shade entries that draws can reach, then
// runs directed loads, span shapes and view window settings, then random
// phases under several register settings. Each accepted draw is rendered
// by a local copy of the tables and registers into a queue of pixel
// groups, and every group beat from the block is compared field by field
// against the head of that queue.
// ---------------------------------------------------------------------------
module tb_top;

    import fstm_pkg::*;

    localparam int MAX_SPAN    = 512;
    localparam int MAX_COLUMNS = 1024;
    localparam int PRINT_CAP   = 40;
    localparam int TEX_FILL    = 64;
    localparam int SHADE_FILL  = 32;

    typedef struct packed {
        logic [10:0] column;
        logic [10:0] row;
        logic [63:0] pixels;
        logic [3:0]  count;
        logic        last;
        logic        cut;
    } group_t;

    typedef struct {
        op_t         op;
        logic [11:0] index;
        logic [7:0]  value;
        logic [9:0]  x_first;
        logic [9:0]  x_last;
        logic [9:0]  row;
        logic [31:0] u0;
        logic [31:0] v0;
        logic [31:0] du;
        logic [31:0] dv;
    } item_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [11:0] table_index;
    logic [7:0]  table_value;
    logic [9:0]  start_column;
    logic [9:0]  end_column;
    logic [9:0]  span_row;
    logic [31:0] u_start;
    logic [31:0] v_start;
    logic [31:0] u_step;
    logic [31:0] v_step;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IW-1:0] cfg_index;
    logic [9:0]  cfg_data;
    logic        strobe;
    logic [10:0] group_column;
    logic [10:0] group_row;
    logic [63:0] pixel_group;
    logic [3:0]  pixel_count;
    logic        last_group;
    logic        span_cut;

    logic [7:0] texture_copy [4096];
    logic [7:0] shade_copy [256];
    logic [9:0] view_left;
    logic [9:0] view_top;
    logic       bypass_copy;

    group_t span_groups [$];

    int errors;
    int draws_sent;
    int cut_draws;
    int loads_sent;
    int groups_seen;
    int cfg_writes;
    bit gaps_on;
    int burst_left;

    flat_span_texture_mapper #(
        .MAX_SPAN    (MAX_SPAN),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .table_index  (table_index),
        .table_value  (table_value),
        .start_column (start_column),
        .end_column   (end_column),
        .span_row     (span_row),
        .u_start      (u_start),
        .v_start      (v_start),
        .u_step       (u_step),
        .v_step       (v_step),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .strobe       (strobe),
        .group_column (group_column),
        .group_row    (group_row),
        .pixel_group  (pixel_group),
        .pixel_count  (pixel_count),
        .last_group   (last_group),
        .span_cut     (span_cut)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic report(input string msg);
        errors++;
        if (errors <= PRINT_CAP)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // walk one item through the local tables; draws queue their groups
    task automatic render_item(input item_t it);
        logic [31:0] pos;
        logic [31:0] step;
        logic [11:0] spot;
        logic [7:0]  texel;
        int unsigned x1;
        int unsigned x2;
        int unsigned len;
        int unsigned done;
        int unsigned cnt;
        bit          cut;
        group_t      g;
        case (it.op)
            OP_LOAD_TEXEL:
                texture_copy[it.index] = it.value;
            OP_LOAD_SHADE:
                if (it.index < 12'd256)
                    shade_copy[it.index[7:0]] = it.value;
            OP_DRAW:
            begin
                x1 = it.x_first;
                x2 = it.x_last;
                if (x1 < MAX_COLUMNS)
                begin
                    if (x2 >= MAX_COLUMNS)
                        x2 = MAX_COLUMNS - 1;
                    if (x2 >= x1)
                    begin
                        len = x2 - x1 + 1;
                        cut = (len > MAX_SPAN);
                        if (cut)
                            len = MAX_SPAN;
                        cut_draws += cut;
                        pos  = ((it.u0 << 10) & 32'hffff0000) | ((it.v0 >> 6) & 32'h0000ffff);
                        step = ((it.du << 10) & 32'hffff0000) | ((it.dv >> 6) & 32'h0000ffff);
                        done = 0;
                        while (done < len)
                        begin
                            cnt = (len - done > LANES) ? LANES : len - done;
                            g = '0;
                            for (int k = 0; k < cnt; k++)
                            begin
                                spot = 12'(((pos >> 4) & 32'h00000fc0) | (pos >> 26));
                                texel = texture_copy[spot];
                                if (!bypass_copy)
                                    texel = shade_copy[texel];
                                g.pixels[8*k +: 8] = texel;
                                pos = pos + step;
                            end
                            g.column = 11'(view_left + x1 + done);
                            g.row    = 11'(view_top) + 11'(it.row);
                            g.count  = 4'(cnt);
                            g.last   = (done + cnt >= len);
                            g.cut    = cut;
                            span_groups.push_back(g);
                            done += cnt;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic idle(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // hold start low until every queued group has come back, then wait more
    task automatic settle(input int extra);
        do
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        while (span_groups.size() != 0);
        idle(extra);
    endtask

    task automatic send_item(input item_t it);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                idle($urandom_range(1, 12));
                burst_left = $urandom_range(1, 10);
            end
            burst_left--;
        end
        @(negedge clk);
        start        <= 1'b1;
        operation    <= it.op;
        table_index  <= it.index;
        table_value  <= it.value;
        start_column <= it.x_first;
        end_column   <= it.x_last;
        span_row     <= it.row;
        u_start      <= it.u0;
        v_start      <= it.v0;
        u_step       <= it.du;
        v_step       <= it.dv;
        do
            @(posedge clk);
        while (busy);
        if (it.op == OP_DRAW)
            draws_sent++;
        else if (it.op != OP_UNUSED)
            loads_sent++;
        render_item(it);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [9:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_WINDOW_LEFT: view_left   = data;
            CFG_WINDOW_TOP:  view_top    = data;
            CFG_BYPASS:      bypass_copy = data[0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_view(input logic [9:0] left, input logic [9:0] top, input bit bypass);
        settle(20);
        cfg_write(CFG_WINDOW_LEFT, left);
        cfg_write(CFG_WINDOW_TOP, top);
        cfg_write(CFG_BYPASS, {9'($urandom), bypass});
    endtask

    // v start on texel row 0, bits outside the packed field left random
    function automatic logic [31:0] flat_v();
        return $urandom & 32'hffc0ffff;
    endfunction

    // v step that keeps the walk on one texel row
    function automatic logic [31:0] flat_dv();
        return $urandom & 32'hffc0003f;
    endfunction

    function automatic item_t load_item(input op_t op, input logic [11:0] idx,
                                        input logic [7:0] val);
        item_t it;
        it.op      = op;
        it.index   = idx;
        it.value   = val;
        it.x_first = 10'($urandom);
        it.x_last  = 10'($urandom);
        it.row     = 10'($urandom);
        it.u0      = $urandom;
        it.v0      = $urandom;
        it.du      = $urandom;
        it.dv      = $urandom;
        return it;
    endfunction

    function automatic item_t draw_item(input logic [9:0] x1, input logic [9:0] x2,
                                        input logic [9:0] row,
                                        input logic [31:0] u0, input logic [31:0] v0,
                                        input logic [31:0] du, input logic [31:0] dv);
        item_t it;
        it = load_item(OP_DRAW, 12'($urandom), 8'($urandom));
        it.x_first = x1;
        it.x_last  = x2;
        it.row     = row;
        it.u0      = u0;
        it.v0      = v0;
        it.du      = du;
        it.dv      = dv;
        return it;
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int          pick;
        int          shape;
        int unsigned x1;
        int unsigned x2;
        logic [11:0] tidx;
        logic [7:0]  tval;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            shape = $urandom_range(19);
            if (shape < 15)
            begin
                x1 = $urandom_range(1023);
                x2 = x1 + $urandom_range(63);
                if (x2 > 1023)
                    x2 = 1023;
            end
            else if (shape < 17)
            begin
                x1 = $urandom_range(1, 1023);
                x2 = $urandom_range(x1 - 1);
            end
            else
            begin
                x1 = $urandom_range(511);
                x2 = $urandom_range(x1 + 256, 1023);
            end
            it = draw_item(10'(x1), 10'(x2), 10'($urandom), $urandom, flat_v(),
                           $urandom, flat_dv());
        end
        else if (pick < 72)
        begin
            tidx = 12'($urandom);
            if ($urandom_range(1))
                tidx = 12'($urandom_range(TEX_FILL - 1));
            // texels on the drawn row stay within the loaded shade entries
            tval = (tidx < 12'(TEX_FILL)) ? 8'($urandom_range(SHADE_FILL - 1))
                                           : 8'($urandom);
            it = load_item(OP_LOAD_TEXEL, tidx, tval);
        end
        else if (pick < 92)
            it = load_item(OP_LOAD_SHADE,
                           ($urandom_range(1)) ? 12'($urandom_range(255)) : 12'($urandom),
                           8'($urandom));
        else
            it = load_item(OP_UNUSED, 12'($urandom), 8'($urandom));
        return it;
    endfunction

    // every table entry that a draw can reach gets a value first
    task automatic test_preload();
        gaps_on = 1'b0;
        for (int i = 0; i < TEX_FILL; i++)
            send_item(load_item(OP_LOAD_TEXEL, 12'(i), 8'($urandom_range(SHADE_FILL - 1))));
        for (int i = 0; i < SHADE_FILL; i++)
            send_item(load_item(OP_LOAD_SHADE, 12'(i), 8'($urandom)));
    endtask

    task automatic test_table_loads();
        gaps_on = 1'b1;
        send_item(load_item(OP_LOAD_TEXEL, 12'd0, 8'hff));
        send_item(load_item(OP_LOAD_TEXEL, 12'd4095, 8'h00));
        send_item(load_item(OP_LOAD_SHADE, 12'd255, 8'h00));
        send_item(load_item(OP_LOAD_SHADE, 12'd0, 8'hff));
        // shade index above 255 must leave the table alone
        send_item(load_item(OP_LOAD_SHADE, 12'd300, 8'h5a));
        send_item(load_item(OP_LOAD_SHADE, 12'd4095, 8'ha5));
        send_item(load_item(OP_UNUSED, 12'hfff, 8'hff));
        send_item(draw_item(10'd0, 10'd7, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0));
        send_item(draw_item(10'd20, 10'd24, 10'd1, 32'h003f0000, 32'h003f0000,
                            32'h0, 32'h0));
    endtask

    task automatic test_span_shapes();
        send_item(draw_item(10'd5, 10'd5, 10'd2, $urandom, flat_v(), $urandom, flat_dv()));
        send_item(draw_item(10'd8, 10'd15, 10'd3, $urandom, flat_v(), 32'h00010000,
                            32'h0));
        send_item(draw_item(10'd30, 10'd38, 10'd4, $urandom, flat_v(), $urandom, flat_dv()));
        send_item(draw_item(10'd0, 10'd511, 10'd5, $urandom, flat_v(), $urandom, flat_dv()));
        send_item(draw_item(10'd0, 10'd1023, 10'd6, $urandom, flat_v(), $urandom,
                            flat_dv()));
        send_item(draw_item(10'd100, 10'd1023, 10'd7, $urandom, flat_v(), $urandom,
                            flat_dv()));
        send_item(draw_item(10'd10, 10'd9, 10'd8, $urandom, flat_v(), $urandom, flat_dv()));
        send_item(draw_item(10'd1023, 10'd0, 10'd9, $urandom, flat_v(), $urandom,
                            flat_dv()));
        send_item(draw_item(10'd1016, 10'd1023, 10'd1023, 32'h7fffffff, 32'h80000000,
                            32'h80000000, 32'h7fc0003f));
        send_item(draw_item(10'd40, 10'd60, 10'd0, 32'hffffffff, 32'h00000000,
                            32'hfffe8000, 32'hffc0003f));
    endtask

    task automatic test_view_window();
        set_view(10'd1023, 10'd1023, 1'b1);
        send_item(draw_item(10'd1000, 10'd1023, 10'd1023, $urandom, flat_v(), $urandom,
                            flat_dv()));
        set_view(10'd1023, 10'd0, 1'b0);
        send_item(draw_item(10'd0, 10'd19, 10'd512, $urandom, flat_v(), $urandom,
                            flat_dv()));
        set_view(10'd0, 10'd1023, 1'b1);
        // unknown register index must change nothing
        cfg_write(CFG_NONE, 10'h3ff);
        send_item(draw_item(10'd600, 10'd640, 10'd1, $urandom, flat_v(), $urandom,
                            flat_dv()));
        set_view(10'd0, 10'd0, 1'b0);
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 4; phase++)
        begin
            gaps_on = (phase != 1);
            if (phase == 0)
                set_view(10'd0, 10'd0, 1'b1);
            else if (phase == 3)
                set_view(10'd1023, 10'd1023, 1'b0);
            else
                set_view(10'($urandom), 10'($urandom), 1'($urandom));
            cfg_write(CFG_NONE, 10'($urandom));
            for (int i = 0; i < 16; i++)
            begin
                send_item(random_item());
                if ($urandom_range(19) == 0)
                    settle(0);
            end
        end
    endtask

    always @(posedge clk)
    begin
        group_t want;
        if (rst_n && strobe)
        begin
            groups_seen++;
            if (span_groups.size() == 0)
                report($sformatf("unexpected group beat at column %0d", group_column));
            else
            begin
                want = span_groups.pop_front();
                if (group_column !== want.column)
                    report($sformatf("group_column got %0d want %0d",
                                     group_column, want.column));
                if (group_row !== want.row)
                    report($sformatf("group_row got %0d want %0d", group_row, want.row));
                if (pixel_group !== want.pixels)
                    report($sformatf("pixel_group got %h want %h at column %0d",
                                     pixel_group, want.pixels, want.column));
                if (pixel_count !== want.count)
                    report($sformatf("pixel_count got %0d want %0d",
                                     pixel_count, want.count));
                if (last_group !== want.last)
                    report($sformatf("last_group got %b want %b", last_group, want.last));
                if (span_cut !== want.cut)
                    report($sformatf("span_cut got %b want %b", span_cut, want.cut));
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = OP_LOAD_TEXEL;
        table_index  = '0;
        table_value  = '0;
        start_column = '0;
        end_column   = '0;
        span_row     = '0;
        u_start      = '0;
        v_start      = '0;
        u_step       = '0;
        v_step       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_WINDOW_LEFT;
        cfg_data     = '0;
        view_left    = '0;
        view_top     = '0;
        bypass_copy  = 1'b0;
        errors       = 0;
        draws_sent   = 0;
        cut_draws    = 0;
        loads_sent   = 0;
        groups_seen  = 0;
        cfg_writes   = 0;
        gaps_on      = 1'b0;
        burst_left   = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_preload();
        test_table_loads();
        test_span_shapes();
        test_view_window();
        test_random();
        settle(32);

        $display("covered %0d draws (%0d cut), %0d table loads, %0d register writes",
                 draws_sent, cut_draws, loads_sent, cfg_writes);
        $display("checked %0d pixel groups across window and bypass settings",
                 groups_seen);
        if (errors == 0)
            $display("flat_span_texture_mapper: match");
        else
            $display("flat_span_texture_mapper: mismatch");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d groups outstanding", span_groups.size());
        $display("flat_span_texture_mapper: mismatch");
        $finish;
    end

endmodule
